### hw/rtl/nsf_pkg.sv
// Shared constants and helpers for the NMEA sentence framer.
package nsf_pkg;

   localparam int unsigned NumRegs  = 5;
   localparam int unsigned CsrIdxW  = 3;

   localparam logic [7:0] ChStart = 8'h24;  // '$'
   localparam logic [7:0] ChDelim = 8'h2A;  // '*'
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChZero  = 8'h30;  // '0'
   localparam logic [7:0] ChLowA  = 8'h61;  // 'a'

   // Register indexes
   localparam logic [CsrIdxW-1:0] RegTalkerFirst  = 3'd0;
   localparam logic [CsrIdxW-1:0] RegTalkerSecond = 3'd1;
   localparam logic [CsrIdxW-1:0] RegSentenceA    = 3'd2;
   localparam logic [CsrIdxW-1:0] RegSentenceB    = 3'd3;
   localparam logic [CsrIdxW-1:0] RegSentenceC    = 3'd4;

   // Reset values: "GPGGA"
   localparam logic [7:0] RstTalkerFirst  = 8'd71;
   localparam logic [7:0] RstTalkerSecond = 8'd80;
   localparam logic [7:0] RstSentenceA    = 8'd71;
   localparam logic [7:0] RstSentenceB    = 8'd71;
   localparam logic [7:0] RstSentenceC    = 8'd65;

   function automatic logic [7:0] hex_lower(input logic [3:0] nib);
      if (nib < 4'd10) begin
         hex_lower = ChZero + {4'd0, nib};
      end else begin
         hex_lower = ChLowA + {4'd0, nib - 4'd10};
      end
   endfunction

endpackage

### hw/rtl/nmea_sentence_framer.sv
// NMEA sentence framer top level: request register, character sequencer, output register.
//
// Each request expands into 0 to 12 characters, one per cycle on rsp_ unless
// stalled: the six header characters ('$', talker pair, sentence id triple)
// on the first request of a sentence, then the body byte if req_has_data,
// then '*', two lowercase hex checksum digits, CR and LF (LF with
// rsp_end_of_sentence) if req_last_byte. The checksum is the XOR of all
// characters between '$' and '*'. A request holds the request register until
// its last character enters the output register; body-only requests flow at
// one per cycle while rsp_ready holds, and a request that yields nothing is
// absorbed at acceptance. The character sequencer that walks the slots of a
// held request sets that rate. Header characters come from the csr registers
// (indexes 0..4, others ignored), which must only be written while the framer is idle.
module nmea_sentence_framer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_has_data,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_end_of_sentence,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [nsf_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [7:0]                   csr_data
);
   import nsf_pkg::*;

   // Character positions within one request's output burst
   typedef enum logic [3:0] {
      SLOT_START  = 4'd0,
      SLOT_HDR0   = 4'd1,
      SLOT_HDR1   = 4'd2,
      SLOT_HDR2   = 4'd3,
      SLOT_HDR3   = 4'd4,
      SLOT_HDR4   = 4'd5,
      SLOT_DATA   = 4'd6,
      SLOT_DELIM  = 4'd7,
      SLOT_HEX_HI = 4'd8,
      SLOT_HEX_LO = 4'd9,
      SLOT_CR     = 4'd10,
      SLOT_LF     = 4'd11
   } slot_type;

   // configuration registers
   logic [7:0] hdr_ff [NumRegs];

   // sentence state
   logic       in_sentence_ff, in_sentence_in;
   logic [7:0] xor_ff, xor_in;

   // request register
   logic       busy_ff, busy_in;
   slot_type   slot_ff, slot_in;
   logic [7:0] data_ff;
   logic       has_ff, last_ff;
   logic [7:0] chk_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_eos_ff;

   logic       accept, advance, next_ok, first_ok;
   slot_type   next_slot, first_slot;
   logic [7:0] hdr_xor, xor_base, xor_after;
   logic [7:0] cur_byte;
   logic       cur_eos;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff[RegTalkerFirst]  <= RstTalkerFirst;
         hdr_ff[RegTalkerSecond] <= RstTalkerSecond;
         hdr_ff[RegSentenceA]    <= RstSentenceA;
         hdr_ff[RegSentenceB]    <= RstSentenceB;
         hdr_ff[RegSentenceC]    <= RstSentenceC;
      end else if (csr_valid && (csr_index < CsrIdxW'(NumRegs))) begin
         hdr_ff[csr_index] <= csr_data;
      end
   end

   // Sequencer moves one character into the output register when it is free.
   assign advance   = busy_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      next_ok   = 1'b1;
      next_slot = SLOT_START;
      case (slot_ff)
         SLOT_START:  next_slot = SLOT_HDR0;
         SLOT_HDR0:   next_slot = SLOT_HDR1;
         SLOT_HDR1:   next_slot = SLOT_HDR2;
         SLOT_HDR2:   next_slot = SLOT_HDR3;
         SLOT_HDR3:   next_slot = SLOT_HDR4;
         SLOT_HDR4: begin
            if (has_ff) next_slot = SLOT_DATA;
            else if (last_ff) next_slot = SLOT_DELIM;
            else next_ok = 1'b0;
         end
         SLOT_DATA: begin
            if (last_ff) next_slot = SLOT_DELIM;
            else next_ok = 1'b0;
         end
         SLOT_DELIM:  next_slot = SLOT_HEX_HI;
         SLOT_HEX_HI: next_slot = SLOT_HEX_LO;
         SLOT_HEX_LO: next_slot = SLOT_CR;
         SLOT_CR:     next_slot = SLOT_LF;
         default:     next_ok = 1'b0;
      endcase
   end

   // Free when empty or when the held request sends its final character now.
   assign req_ready = !busy_ff || (advance && !next_ok);
   assign accept    = req_valid && req_ready;

   // Checksum and first slot for the incoming request
   assign hdr_xor   = hdr_ff[RegTalkerFirst] ^ hdr_ff[RegTalkerSecond] ^
                      hdr_ff[RegSentenceA] ^ hdr_ff[RegSentenceB] ^ hdr_ff[RegSentenceC];
   assign xor_base  = in_sentence_ff ? xor_ff : hdr_xor;
   assign xor_after = req_has_data ? (xor_base ^ req_data_byte) : xor_base;

   always_comb begin
      first_ok   = 1'b1;
      first_slot = SLOT_START;
      if (!in_sentence_ff) first_slot = SLOT_START;
      else if (req_has_data) first_slot = SLOT_DATA;
      else if (req_last_byte) first_slot = SLOT_DELIM;
      else first_ok = 1'b0;
   end

   always_comb begin
      in_sentence_in = in_sentence_ff;
      xor_in         = xor_ff;
      busy_in        = busy_ff;
      slot_in        = slot_ff;
      if (advance) begin
         busy_in = next_ok;
         slot_in = next_slot;
      end
      if (accept) begin
         in_sentence_in = !req_last_byte;
         xor_in         = req_last_byte ? 8'd0 : xor_after;
         busy_in        = first_ok;
         slot_in        = first_slot;
      end
   end

   // Character for the current slot
   always_comb begin
      cur_byte = ChStart;
      cur_eos  = 1'b0;
      case (slot_ff)
         SLOT_START:  cur_byte = ChStart;
         SLOT_HDR0:   cur_byte = hdr_ff[RegTalkerFirst];
         SLOT_HDR1:   cur_byte = hdr_ff[RegTalkerSecond];
         SLOT_HDR2:   cur_byte = hdr_ff[RegSentenceA];
         SLOT_HDR3:   cur_byte = hdr_ff[RegSentenceB];
         SLOT_HDR4:   cur_byte = hdr_ff[RegSentenceC];
         SLOT_DATA:   cur_byte = data_ff;
         SLOT_DELIM:  cur_byte = ChDelim;
         SLOT_HEX_HI: cur_byte = hex_lower(chk_ff[7:4]);
         SLOT_HEX_LO: cur_byte = hex_lower(chk_ff[3:0]);
         SLOT_CR:     cur_byte = ChCr;
         SLOT_LF: begin
            cur_byte = ChLf;
            cur_eos  = 1'b1;
         end
         default:     cur_byte = ChStart;
      endcase
   end

   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // state, payload and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         xor_ff         <= 8'd0;
         busy_ff        <= 1'b0;
         slot_ff        <= SLOT_START;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         xor_ff         <= xor_in;
         busy_ff        <= busy_in;
         slot_ff        <= slot_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (accept) begin
            data_ff <= req_data_byte;
            has_ff  <= req_has_data;
            last_ff <= req_last_byte;
            chk_ff  <= xor_after;
         end
         if (advance) begin
            rsp_byte_ff <= cur_byte;
            rsp_eos_ff  <= cur_eos;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_byte        = rsp_byte_ff;
   assign rsp_end_of_sentence = rsp_eos_ff;

endmodule
